// ----- hw/rtl/tesu_pkg.sv -----
// Shared types and constants for the trap entry state update core.
// Holds the transaction structs, configuration indexes and trap encodings.
// No dependencies.
`default_nettype none

package tesu_pkg;

  // Default sizing of the trap and window hierarchy
  localparam int MaxTrapLevelDef       = 6;
  localparam int MaxPrivTrapLevelDef   = 2;
  localparam int MaxGlobalLevelDef     = 3;
  localparam int MaxPrivGlobalLevelDef = 2;
  localparam int NumWindowsDef         = 8;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAP_BASE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HYPER_TRAP_BASE = 2'd1;

  // Target privilege levels
  localparam logic [1:0] LVL_PRIV  = 2'd1;
  localparam logic [1:0] LVL_HYPER = 2'd2;

  // Trap types with special handling
  localparam logic [8:0] TT_WATCHDOG     = 9'h002;
  localparam logic [8:0] TT_CLEAN_WINDOW = 9'h024;
  localparam logic [8:0] TT_SPILL_LO     = 9'h080;
  localparam logic [8:0] TT_SPILL_HI     = 9'h0bf;
  localparam logic [8:0] TT_FILL_LO      = 9'h0c0;
  localparam logic [8:0] TT_FILL_HI      = 9'h0ff;
  localparam logic [8:0] TT_HYPER_SPLIT  = 9'd384;

  // RED state handler address
  localparam logic [63:0] RED_VECTOR = 64'h0000_00ff_f000_00a0;

  // pstate bit positions
  localparam int PS_IE   = 1;
  localparam int PS_PRIV = 2;
  localparam int PS_AM   = 3;
  localparam int PS_PEF  = 4;
  localparam int PS_TLE  = 8;
  localparam int PS_CLE  = 9;

  // hpstate bit positions
  localparam int HPS_TLZ   = 0;
  localparam int HPS_HPRIV = 2;
  localparam int HPS_RED   = 5;
  localparam int HPS_IBE   = 10;

  typedef struct packed {
    logic [8:0]  trap_type;
    logic [1:0]  target_level;
    logic [2:0]  trap_level;
    logic [2:0]  global_level;
    logic [12:0] proc_state;
    logic [10:0] hyper_state;
    logic [2:0]  window_ptr;
    logic [7:0]  cond_codes;
    logic [7:0]  addr_space_id;
    logic [2:0]  can_save;
    logic [63:0] cur_pc;
    logic [63:0] cur_npc;
  } in_t;

  typedef struct packed {
    logic [2:0]  new_trap_level;
    logic [2:0]  new_global_level;
    logic [12:0] new_proc_state;
    logic [10:0] new_hyper_state;
    logic [2:0]  new_window_ptr;
    logic [42:0] saved_trap_state;
    logic [63:0] saved_pc;
    logic [63:0] saved_npc;
    logic [63:0] handler_pc;
    logic [63:0] handler_npc;
    logic        trap_error;
  } out_t;

  typedef struct packed {
    logic [63:0] trap_base;
    logic [63:0] hyper_trap_base;
  } bases_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tesu_cfg_regs.sv -----
// Configuration register file: privileged and hyperprivileged trap bases.
// Depends on tesu_pkg for register indexes and the bases_t struct.
`default_nettype none

module tesu_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tesu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]                    cfg_data,
  output tesu_pkg::bases_t                    bases
);

  tesu_pkg::bases_t bases_q;

  // Take writes whenever out of reset
  assign cfg_ready = !rst;

  // Update the addressed register; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      bases_q <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tesu_pkg::CFG_TRAP_BASE: begin
          bases_q.trap_base <= cfg_data;
        end
        tesu_pkg::CFG_HYPER_TRAP_BASE: begin
          bases_q.hyper_trap_base <= cfg_data;
        end
        default: begin
          bases_q <= bases_q;
        end
      endcase
    end
  end

  assign bases = bases_q;

endmodule

`default_nettype wire

// ----- hw/rtl/tesu_trap_logic.sv -----
// Combinational trap entry evaluation: path select, new state, vectors.
// Depends on tesu_pkg for in_t, out_t, bases_t and trap encodings.
`default_nettype none

module tesu_trap_logic #(
  parameter int MAX_TRAP_LEVEL        = tesu_pkg::MaxTrapLevelDef,
  parameter int MAX_PRIV_TRAP_LEVEL   = tesu_pkg::MaxPrivTrapLevelDef,
  parameter int MAX_GLOBAL_LEVEL      = tesu_pkg::MaxGlobalLevelDef,
  parameter int MAX_PRIV_GLOBAL_LEVEL = tesu_pkg::MaxPrivGlobalLevelDef,
  parameter int NUM_WINDOWS           = tesu_pkg::NumWindowsDef
) (
  input  wire tesu_pkg::in_t    item,
  input  wire tesu_pkg::bases_t bases,
  output tesu_pkg::out_t        result
);

  localparam logic [2:0] MaxTl      = 3'(MAX_TRAP_LEVEL);
  localparam logic [2:0] RedTl      = 3'(MAX_TRAP_LEVEL - 1);
  localparam logic [2:0] MaxPrivTl  = 3'(MAX_PRIV_TRAP_LEVEL);
  localparam logic [3:0] MaxGl      = 4'(MAX_GLOBAL_LEVEL);
  localparam logic [3:0] MaxPrivGl  = 4'(MAX_PRIV_GLOBAL_LEVEL);
  localparam logic [4:0] NumWin     = 5'(NUM_WINDOWS);
  // Largest window sum is cwp + cansave + 2 = 16
  localparam int         WrapSteps  = 16 / NUM_WINDOWS;

  // Reduce a small window sum modulo the window count
  function automatic logic [2:0] wrap_window(input logic [4:0] v);
    logic [4:0] r;
    r = v;
    for (int i = 0; i < WrapSteps; i++) begin
      if (r >= NumWin) r = r - NumWin;
    end
    return r[2:0];
  endfunction

  logic        red;
  logic        err;
  logic        red_path;
  logic        watchdog;
  logic        hyper;
  logic [3:0]  gl_inc;
  logic [2:0]  gl_cap_hyper;
  logic [2:0]  gl_cap_priv;
  logic [8:0]  vec_tt;
  logic [4:0]  cwp5;
  logic [2:0]  cwp_adj;
  logic [12:0] ps_base;
  logic [12:0] ps_priv;
  logic [63:0] hpc;

  // Path selection
  always_comb begin
    red      = item.hyper_state[tesu_pkg::HPS_RED];
    err      = !red && (item.trap_level >= MaxTl);
    red_path = red || (item.trap_level == RedTl);
    watchdog = (item.trap_level > MaxPrivTl) && (item.target_level == tesu_pkg::LVL_PRIV);
    hyper    = watchdog || (item.target_level == tesu_pkg::LVL_HYPER) ||
               ((item.target_level == tesu_pkg::LVL_PRIV) &&
                (item.trap_type >= tesu_pkg::TT_HYPER_SPLIT));
  end

  // Global level increment with per-path cap
  always_comb begin
    gl_inc       = {1'b0, item.global_level} + 4'd1;
    gl_cap_hyper = (gl_inc < MaxGl)     ? gl_inc[2:0] : MaxGl[2:0];
    gl_cap_priv  = (gl_inc < MaxPrivGl) ? gl_inc[2:0] : MaxPrivGl[2:0];
  end

  // Window pointer adjust for clean, spill and fill traps
  always_comb begin
    cwp5    = {2'b00, item.window_ptr};
    cwp_adj = item.window_ptr;
    if (item.trap_type == tesu_pkg::TT_CLEAN_WINDOW) begin
      cwp_adj = wrap_window(cwp5 + 5'd1);
    end else if (item.trap_type >= tesu_pkg::TT_SPILL_LO &&
                 item.trap_type <= tesu_pkg::TT_SPILL_HI) begin
      cwp_adj = wrap_window(cwp5 + {2'b00, item.can_save} + 5'd2);
    end else if (item.trap_type >= tesu_pkg::TT_FILL_LO &&
                 item.trap_type <= tesu_pkg::TT_FILL_HI) begin
      cwp_adj = wrap_window(cwp5 + NumWin - 5'd1);
    end
  end

  // pstate for the handler paths: set pef, clear ie and am; privileged path also sets priv, cle = tle
  always_comb begin
    ps_base = item.proc_state;
    ps_base[tesu_pkg::PS_PEF] = 1'b1;
    ps_base[tesu_pkg::PS_IE]  = 1'b0;
    ps_base[tesu_pkg::PS_AM]  = 1'b0;
    ps_priv = ps_base;
    ps_priv[tesu_pkg::PS_PRIV] = 1'b1;
    ps_priv[tesu_pkg::PS_CLE]  = ps_base[tesu_pkg::PS_TLE];
    vec_tt = watchdog ? tesu_pkg::TT_WATCHDOG : item.trap_type;
  end

  // Assemble the result
  always_comb begin
    result = '0;
    hpc    = '0;
    if (err) begin
      result.new_trap_level   = item.trap_level;
      result.new_global_level = item.global_level;
      result.new_proc_state   = item.proc_state;
      result.new_hyper_state  = item.hyper_state;
      result.new_window_ptr   = item.window_ptr;
      result.handler_pc       = item.cur_pc;
      result.handler_npc      = item.cur_npc;
      result.trap_error       = 1'b1;
    end else begin
      result.new_trap_level   = (item.trap_level == 3'd7) ? 3'd7 : item.trap_level + 3'd1;
      result.new_window_ptr   = cwp_adj;
      result.saved_trap_state = {item.global_level, item.cond_codes, item.addr_space_id,
                                 3'b000, item.proc_state, 5'b00000, item.window_ptr};
      if (item.proc_state[tesu_pkg::PS_AM]) begin
        result.saved_pc  = {32'd0, item.cur_pc[31:0]};
        result.saved_npc = {32'd0, item.cur_npc[31:0]};
      end else begin
        result.saved_pc  = item.cur_pc;
        result.saved_npc = item.cur_npc;
      end
      if (red_path) begin
        result.new_global_level = gl_cap_hyper;
        result.new_proc_state   = '0;
        result.new_proc_state[tesu_pkg::PS_PRIV] = 1'b1;
        result.new_proc_state[tesu_pkg::PS_PEF]  = 1'b1;
        result.new_hyper_state  = item.hyper_state;
        result.new_hyper_state[tesu_pkg::HPS_RED]   = 1'b1;
        result.new_hyper_state[tesu_pkg::HPS_HPRIV] = 1'b1;
        result.new_hyper_state[tesu_pkg::HPS_IBE]   = 1'b0;
        result.new_hyper_state[tesu_pkg::HPS_TLZ]   = 1'b0;
        hpc = tesu_pkg::RED_VECTOR;
      end else if (hyper) begin
        result.new_global_level = gl_cap_hyper;
        result.new_proc_state   = ps_base;
        result.new_proc_state[tesu_pkg::PS_CLE] = 1'b0;
        result.new_hyper_state  = item.hyper_state;
        result.new_hyper_state[tesu_pkg::HPS_IBE]   = 1'b0;
        result.new_hyper_state[tesu_pkg::HPS_RED]   = 1'b0;
        result.new_hyper_state[tesu_pkg::HPS_HPRIV] = 1'b1;
        hpc = {bases.hyper_trap_base[63:14], vec_tt, 5'b00000};
      end else begin
        result.new_global_level = gl_cap_priv;
        result.new_proc_state   = ps_priv;
        result.new_hyper_state  = item.hyper_state;
        hpc = {bases.trap_base[63:15], (item.trap_level != 3'd0), item.trap_type, 5'b00000};
      end
      result.handler_pc  = hpc;
      result.handler_npc = hpc + 64'd4;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/trap_entry_state_update_core.sv -----
// Trap entry state update core: top level with input and result registers.
// Depends on tesu_pkg, tesu_cfg_regs and tesu_trap_logic.
//
// Usage:
//   Command channel: a transaction is taken at a clock edge where start is
//   high and busy is low. busy is high only while rst is asserted, so a new
//   trap can be issued every cycle.
//   Result channel: done pulses for one cycle with the result struct; the
//   receiver cannot stall, so every result must be taken in that cycle.
//   Path: from the accepting edge, the transaction passes the input register
//   and then the result register before done. Throughput: 1 per cycle,
//   set by the single registered pass through the trap evaluation logic.
//   Configuration: cfg_valid/cfg_ready write channel, index 0 is the
//   privileged trap base, index 1 the hyperprivileged trap base; other
//   indexes are ignored. Write only while no trap is in flight.
//   Reset (synchronous, active high) clears both trap bases and drops any
//   transaction in flight; no result is produced for it.
`default_nettype none

module trap_entry_state_update_core #(
  parameter int MAX_TRAP_LEVEL        = tesu_pkg::MaxTrapLevelDef,
  parameter int MAX_PRIV_TRAP_LEVEL   = tesu_pkg::MaxPrivTrapLevelDef,
  parameter int MAX_GLOBAL_LEVEL      = tesu_pkg::MaxGlobalLevelDef,
  parameter int MAX_PRIV_GLOBAL_LEVEL = tesu_pkg::MaxPrivGlobalLevelDef,
  parameter int NUM_WINDOWS           = tesu_pkg::NumWindowsDef
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire tesu_pkg::in_t                  item,
  output logic                                done,
  output tesu_pkg::out_t                      result,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tesu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]                    cfg_data
);

  tesu_pkg::bases_t bases;
  tesu_pkg::in_t    item_q;
  logic             item_valid;
  tesu_pkg::out_t   eval;
  tesu_pkg::out_t   result_q;
  logic             done_q;

  assign busy = rst;

  tesu_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .bases     (bases)
  );

  // Capture the incoming transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_q <= item;
    end
  end

  tesu_trap_logic #(
    .MAX_TRAP_LEVEL        (MAX_TRAP_LEVEL),
    .MAX_PRIV_TRAP_LEVEL   (MAX_PRIV_TRAP_LEVEL),
    .MAX_GLOBAL_LEVEL      (MAX_GLOBAL_LEVEL),
    .MAX_PRIV_GLOBAL_LEVEL (MAX_PRIV_GLOBAL_LEVEL),
    .NUM_WINDOWS           (NUM_WINDOWS)
  ) u_logic (
    .item   (item_q),
    .bases  (bases),
    .result (eval)
  );

  // Register the result and its strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done_q <= 1'b0;
    end else begin
      done_q <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      result_q <= eval;
    end
  end

  assign done   = done_q;
  assign result = result_q;

endmodule

`default_nettype wire

// ----- hw/rtl/tesu_checker.sv -----
// Port-level checker for the trap entry state update core, bound to the top.
// Depends on tesu_pkg and trap_entry_state_update_core.
`default_nettype none

module tesu_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           done,
  input wire tesu_pkg::out_t result
);

  // Every accepted transaction yields a result, through the input register and then the result register
  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("accepted transaction produced no result");

  // No result appears without an accepted transaction
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without accepted transaction");

  // Redirect results step the handler NPC by one instruction
  a_npc_step: assert property (@(posedge clk) disable iff (rst)
    (done && !result.trap_error) |-> (result.handler_npc == result.handler_pc + 64'd4))
    else $error("handler NPC is not handler PC plus four");

  // Error state saves nothing
  a_error_no_save: assert property (@(posedge clk) disable iff (rst)
    (done && result.trap_error) |->
      (result.saved_trap_state == '0 && result.saved_pc == '0 && result.saved_npc == '0))
    else $error("error state result carries saved state");

endmodule

bind trap_entry_state_update_core tesu_checker u_tesu_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire
